/* rtl/mqtt_control_packet_receiver_top_macros.svh */
// ----------------------------------------------------------------------------
// mqtt receiver assertion macros
// shared concurrent assertion forms, clocked on clk_i, quiet during reset
// ----------------------------------------------------------------------------
`ifndef MQTT_CONTROL_PACKET_RECEIVER_TOP_MACROS_SVH
`define MQTT_CONTROL_PACKET_RECEIVER_TOP_MACROS_SVH

// property that must hold at every clock edge out of reset
`define MQTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define MQTT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MQTT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mqtt_rx_pkg.sv */
// ----------------------------------------------------------------------------
// mqtt receiver package
// packet and result kinds, type table, result record and queue sizing
// ----------------------------------------------------------------------------
package mqtt_rx_pkg;

  // topic bytes streamed out per publish
  localparam int TOPIC_KEEP = 41;

  // result queue depth and pointer widths
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int NUM_TYPES = 9;
  localparam logic [17:0] BODY_MAX = 18'h3ffff;

  typedef enum logic [3:0] {
    PK_CONNACK  = 4'd0,
    PK_PUBLISH  = 4'd1,
    PK_PUBACK   = 4'd2,
    PK_PUBREC   = 4'd3,
    PK_PUBREL   = 4'd4,
    PK_PUBCOMP  = 4'd5,
    PK_SUBACK   = 4'd6,
    PK_UNSUBACK = 4'd7,
    PK_PINGRESP = 4'd8,
    PK_NONE     = 4'd15
  } pk_e;

  typedef enum logic [1:0] {
    RK_TOPIC   = 2'd0,
    RK_PAYLOAD = 2'd1,
    RK_EVENT   = 2'd2
  } rk_e;

  typedef enum logic [1:0] {
    RD_NONE    = 2'd0,
    RD_PUBACK  = 2'd1,
    RD_PUBREC  = 2'd2,
    RD_PUBCOMP = 2'd3
  } reply_e;

  // fixed header codes, in match priority order
  localparam logic [7:0] TYPE_CODES [NUM_TYPES] = '{
    8'h20, 8'h30, 8'h40, 8'h50, 8'h62, 8'h70, 8'h90, 8'hb0, 8'hd0
  };

  typedef struct packed {
    rk_e          kind;
    logic [7:0]   data_byte;
    logic [3:0]   packet_kind;
    logic [15:0]  packet_id;
    logic [7:0]   status_code;
    logic [1:0]   qos_level;
    logic [15:0]  topic_length;
    logic [7:0]   payload_length;
    reply_e       reply_due;
    logic         length_error;
    logic         last;
  } res_t;

  // up to two results per accepted byte
  typedef struct packed {
    logic [1:0] n;
    res_t       res0;
    res_t       res1;
  } res_pair_t;

  // header byte to packet kind
  function automatic pk_e classify(input logic [7:0] hdr, input logic upper);
    pk_e  k;
    logic hit;
    k   = PK_NONE;
    hit = 1'b0;
    for (int i = 0; i < NUM_TYPES; i++) begin
      if (!hit && ((upper && TYPE_CODES[i] == (hdr & 8'hf0)) || TYPE_CODES[i] == hdr)) begin
        k   = pk_e'(4'(i));
        hit = 1'b1;
      end
    end
    return k;
  endfunction

  // remaining length a fixed-size packet must carry
  function automatic logic [1:0] expected_len(input pk_e pk);
    logic [1:0] len;
    case (pk)
      PK_SUBACK:   len = 2'd3;
      PK_PUBLISH:  len = 2'd0;
      PK_PINGRESP: len = 2'd0;
      default:     len = 2'd2;
    endcase
    return len;
  endfunction

endpackage

/* rtl/mqtt_control_packet_receiver_top.sv */
// ----------------------------------------------------------------------------
// mqtt control packet receiver
// parses server-to-client packet bytes into topic, payload and event items
//
//   channel   dir  handshake                 contents
//   s_axis    in   tvalid/tready             tdata rx_byte, tlast end_of_packet
//   m_axis    out  tvalid/tready             tuser kind, tdata data byte and
//                                            event fields, tlast last
//   cfg       in   cfg_we_i                  cfg_wdata_i match_upper_nibble
//
// one byte per cycle while the result queue has room: an input register,
// combinational decode, then a four-entry result queue; a byte makes at most
// two items (data and event); input stalls only when a byte waits in the
// input register and the result queue holds more than two items
// reset clears packet state, queue and sets match_upper_nibble to 1
// ----------------------------------------------------------------------------
module mqtt_control_packet_receiver_top
  import mqtt_rx_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tlast,   // end_of_packet
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] data_byte, [11:8] packet_kind, [27:12] packet_id, [35:28] status_code,
  // [37:36] qos_level, [53:38] topic_length, [61:54] payload_length,
  // [63:62] reply_due, [64] length_error, [71:65] zero
  output logic [71:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast,   // last
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i     // match_upper_nibble
);

  logic       upper_q;
  logic       stage_vld_q, stage_vld_d;
  logic [7:0] stage_byte_q;
  logic       stage_eop_q;
  logic       room;
  logic       fire;
  logic       s_acc;
  res_pair_t  pair;
  res_t       head;

  assign fire          = stage_vld_q && room;
  assign s_axis_tready = !stage_vld_q || fire;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // match mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= 1'b1;
    end else if (cfg_we_i) begin
      upper_q <= cfg_wdata_i;
    end
  end

  // input register
  always_comb begin
    stage_vld_d = stage_vld_q;
    if (s_acc) begin
      stage_vld_d = 1'b1;
    end else if (fire) begin
      stage_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= 1'b0;
    end else begin
      stage_vld_q <= stage_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      stage_byte_q <= s_axis_tdata;
      stage_eop_q  <= s_axis_tlast;
    end
  end

  mqtt_rx_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .byte_i  (stage_byte_q),
    .eop_i   (stage_eop_q),
    .upper_i (upper_q),
    .out_o   (pair)
  );

  mqtt_rx_resq u_resq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (pair),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (head)
  );

  // output packing
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;
  assign m_axis_tdata = {7'b0, head.length_error, head.reply_due, head.payload_length,
                         head.topic_length, head.qos_level, head.status_code,
                         head.packet_id, head.packet_kind, head.data_byte};

endmodule

/* rtl/mqtt_rx_decode.sv */
// ----------------------------------------------------------------------------
// mqtt receiver byte decoder
// per-packet state and the field capture, one packet byte per cycle on fire_i
// ----------------------------------------------------------------------------
`include "mqtt_control_packet_receiver_top_macros.svh"

module mqtt_rx_decode
  import mqtt_rx_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  input  logic       eop_i,
  input  logic       upper_i,
  output res_pair_t  out_o
);

  logic [7:0]  byte_index_q, byte_index_d;
  logic [7:0]  header_q, header_d, header_n;
  logic [20:0] rem_len_q, rem_len_d, rem_len_n;
  logic [1:0]  len_cnt_q, len_cnt_d, len_cnt_n;
  logic        len_done_q, len_done_d, len_done_n;
  logic [15:0] topic_len_q, topic_len_d, topic_len_n;
  logic [15:0] id_q, id_d, id_n;
  logic [7:0]  status_q, status_d, status_n;
  logic [7:0]  pay_cnt_q, pay_cnt_d, pay_cnt_n;
  logic        err_q, err_d, err_n;
  logic [17:0] body_cnt_q, body_cnt_d, body_cnt_n;

  pk_e         body_pk;
  pk_e         ev_pk;
  logic [1:0]  qos;
  logic [17:0] t_p2;
  logic [17:0] t_p3;
  logic        qos_id;
  logic        data_vld;
  res_t        data_res;
  logic        ev_vld;
  logic        ev_err;
  res_t        ev_res;

  assign body_pk = classify(header_q, upper_i);
  assign qos     = header_q[2:1];
  assign qos_id  = (qos == 2'd1) || (qos == 2'd2);
  assign t_p2    = {2'b00, topic_len_q} + 18'd2;
  assign t_p3    = {2'b00, topic_len_q} + 18'd3;

  // header, length field and body capture
  always_comb begin
    header_n    = header_q;
    rem_len_n   = rem_len_q;
    len_cnt_n   = len_cnt_q;
    len_done_n  = len_done_q;
    topic_len_n = topic_len_q;
    id_n        = id_q;
    status_n    = status_q;
    pay_cnt_n   = pay_cnt_q;
    err_n       = err_q;
    body_cnt_n  = body_cnt_q;
    data_vld    = 1'b0;
    data_res    = '0;
    data_res.data_byte = byte_i;
    data_res.last      = 1'b1;
    if (byte_index_q == 8'd0) begin
      header_n = byte_i;
    end else if (!len_done_q) begin
      if (len_cnt_q == 2'd3) begin
        err_n      = 1'b1;
        len_done_n = 1'b1;
      end else begin
        case (len_cnt_q)
          2'd0:    rem_len_n = rem_len_q | {14'b0, byte_i[6:0]};
          2'd1:    rem_len_n = rem_len_q | {7'b0, byte_i[6:0], 7'b0};
          default: rem_len_n = rem_len_q | {byte_i[6:0], 14'b0};
        endcase
        len_cnt_n = len_cnt_q + 2'd1;
        if (!byte_i[7]) begin
          len_done_n = 1'b1;
        end
      end
    end else if (body_pk != PK_NONE) begin
      if (body_pk == PK_PUBLISH) begin
        if (body_cnt_q == 18'd0) begin
          topic_len_n = {byte_i, 8'h00};
        end else if (body_cnt_q == 18'd1) begin
          topic_len_n = {topic_len_q[15:8], byte_i};
        end else if (body_cnt_q < t_p2) begin
          if ((body_cnt_q - 18'd2) < 18'(TOPIC_KEEP)) begin
            data_vld      = 1'b1;
            data_res.kind = RK_TOPIC;
          end
        end else if (qos_id && body_cnt_q == t_p2) begin
          id_n = {byte_i, 8'h00};
        end else if (qos_id && body_cnt_q == t_p3) begin
          id_n = {id_q[15:8], byte_i};
        end else begin
          data_vld      = 1'b1;
          data_res.kind = RK_PAYLOAD;
          if (pay_cnt_q != 8'hff) begin
            pay_cnt_n = pay_cnt_q + 8'd1;
          end
        end
      end else if (body_pk == PK_CONNACK) begin
        if (body_cnt_q == 18'd1) begin
          status_n = byte_i;
        end
      end else if (body_pk != PK_PINGRESP) begin
        if (body_cnt_q == 18'd0) begin
          id_n = {byte_i, 8'h00};
        end else if (body_cnt_q == 18'd1) begin
          id_n = {id_q[15:8], byte_i};
        end else if (body_cnt_q == 18'd2 && body_pk == PK_SUBACK) begin
          status_n = byte_i;
        end
      end
      if (body_cnt_q != BODY_MAX) begin
        body_cnt_n = body_cnt_q + 18'd1;
      end
    end
  end

  assign ev_pk = classify(header_n, upper_i);

  // end-of-packet event
  always_comb begin
    ev_vld = eop_i && (ev_pk != PK_NONE) &&
             ((byte_index_q >= 8'd3) || (ev_pk == PK_PINGRESP));
    ev_err = err_n | ~len_done_n;
    if (ev_pk != PK_PUBLISH && len_done_n &&
        rem_len_n != {19'b0, expected_len(ev_pk)}) begin
      ev_err = 1'b1;
    end
    ev_res             = '0;
    ev_res.kind        = RK_EVENT;
    ev_res.packet_kind = ev_pk;
    ev_res.packet_id   = id_n;
    ev_res.length_error = ev_err;
    ev_res.last        = 1'b1;
    if (ev_pk == PK_CONNACK || ev_pk == PK_SUBACK) begin
      ev_res.status_code = status_n;
    end
    if (ev_pk == PK_PUBLISH) begin
      ev_res.qos_level      = header_n[2:1];
      ev_res.topic_length   = topic_len_n;
      ev_res.payload_length = pay_cnt_n;
      case (header_n[2:1])
        2'd1:    ev_res.reply_due = RD_PUBACK;
        2'd2:    ev_res.reply_due = RD_PUBREC;
        default: ev_res.reply_due = RD_NONE;
      endcase
    end else if (ev_pk == PK_PUBREL) begin
      ev_res.reply_due = RD_PUBCOMP;
    end
  end

  // result pair
  always_comb begin
    out_o      = '0;
    out_o.res0 = data_vld ? data_res : ev_res;
    out_o.res1 = ev_res;
    if (fire_i) begin
      case ({data_vld, ev_vld})
        2'b11: begin
          out_o.n         = 2'd2;
          out_o.res0.last = 1'b0;
        end
        2'b10:   out_o.n = 2'd1;
        2'b01:   out_o.n = 2'd1;
        default: out_o.n = 2'd0;
      endcase
    end
  end

  // next state, cleared after the packet's last byte
  always_comb begin
    byte_index_d = byte_index_q;
    header_d     = header_q;
    rem_len_d    = rem_len_q;
    len_cnt_d    = len_cnt_q;
    len_done_d   = len_done_q;
    topic_len_d  = topic_len_q;
    id_d         = id_q;
    status_d     = status_q;
    pay_cnt_d    = pay_cnt_q;
    err_d        = err_q;
    body_cnt_d   = body_cnt_q;
    if (fire_i) begin
      if (eop_i) begin
        byte_index_d = '0;
        header_d     = '0;
        rem_len_d    = '0;
        len_cnt_d    = '0;
        len_done_d   = 1'b0;
        topic_len_d  = '0;
        id_d         = '0;
        status_d     = '0;
        pay_cnt_d    = '0;
        err_d        = 1'b0;
        body_cnt_d   = '0;
      end else begin
        byte_index_d = (byte_index_q != 8'hff) ? byte_index_q + 8'd1 : byte_index_q;
        header_d     = header_n;
        rem_len_d    = rem_len_n;
        len_cnt_d    = len_cnt_n;
        len_done_d   = len_done_n;
        topic_len_d  = topic_len_n;
        id_d         = id_n;
        status_d     = status_n;
        pay_cnt_d    = pay_cnt_n;
        err_d        = err_n;
        body_cnt_d   = body_cnt_n;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= '0;
      header_q     <= '0;
      rem_len_q    <= '0;
      len_cnt_q    <= '0;
      len_done_q   <= 1'b0;
      topic_len_q  <= '0;
      id_q         <= '0;
      status_q     <= '0;
      pay_cnt_q    <= '0;
      err_q        <= 1'b0;
      body_cnt_q   <= '0;
    end else begin
      byte_index_q <= byte_index_d;
      header_q     <= header_d;
      rem_len_q    <= rem_len_d;
      len_cnt_q    <= len_cnt_d;
      len_done_q   <= len_done_d;
      topic_len_q  <= topic_len_d;
      id_q         <= id_d;
      status_q     <= status_d;
      pay_cnt_q    <= pay_cnt_d;
      err_q        <= err_d;
      body_cnt_q   <= body_cnt_d;
    end
  end

  // checks
  `MQTT_ASSERT_NXT(a_eop_clears, fire_i && eop_i,
    byte_index_q == 8'd0 && !len_done_q && body_cnt_q == 18'd0,
    "packet state not cleared after last byte")
  `MQTT_ASSERT_IMP(a_pair_order, out_o.n == 2'd2,
    out_o.res0.kind != RK_EVENT && out_o.res1.kind == RK_EVENT && !out_o.res0.last,
    "two results must be a data byte then the event")
  `MQTT_ASSERT_IMP(a_single_last, out_o.n == 2'd1, out_o.res0.last,
    "single result must carry last")

endmodule

/* rtl/mqtt_rx_resq.sv */
// ----------------------------------------------------------------------------
// mqtt receiver result queue
// small queue taking up to two results a cycle and giving one a cycle on out_ready_i
// ----------------------------------------------------------------------------
`include "mqtt_control_packet_receiver_top_macros.svh"

module mqtt_rx_resq
  import mqtt_rx_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_pair_t push_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output res_t      out_o
);

  res_t              slots_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              pop;

  assign room_o      = count_q <= QCNT_W'(QDEPTH - 2);
  assign out_valid_o = count_q != '0;
  assign out_o       = slots_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  // pointers and fill
  always_comb begin
    wr_ptr_d = wr_ptr_q + QPTR_W'(push_i.n);
    rd_ptr_d = rd_ptr_q + QPTR_W'(pop);
    count_d  = count_q + QCNT_W'(push_i.n) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // slot writes
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      slots_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.n == 2'd2) begin
      slots_q[wr_ptr_q + QPTR_W'(1)] <= push_i.res1;
    end
  end

  // checks
  `MQTT_ASSERT(a_fill_bound, count_q <= QCNT_W'(QDEPTH), "result queue overfilled")
  `MQTT_ASSERT_IMP(a_push_room, push_i.n != 2'd0, room_o, "push without room")
  `MQTT_ASSERT(a_ptr_gap, QPTR_W'(wr_ptr_q - rd_ptr_q) == QPTR_W'(count_q),
    "queue pointers disagree with fill")

endmodule
